// File: src/lifr_pkg.sv
// Shared types, constants and helpers for the LIF layer with fused readout.
package lifr_pkg;

    localparam int NEURONS_DEF   = 64;
    localparam int OUTPUTS_DEF   = 8;
    localparam int FRAC_BITS_DEF = 12;

    localparam int MEM_W   = 24;
    localparam int VAL_W   = 16;
    localparam int DEC_W   = 13;
    localparam int OP_W    = 3;
    localparam int NIDX_W  = 6;
    localparam int OIDX_W  = 3;
    localparam int NCFG_W  = 7;
    localparam int OCFG_W  = 4;

    localparam logic [MEM_W-1:0] ACC_MAX = 24'h7FFFFF;
    localparam logic [MEM_W-1:0] ACC_MIN = 24'h800000;

    typedef enum logic [OP_W-1:0] {
        OP_STEP  = 3'd0,
        OP_PARAM = 3'd1,
        OP_WEIGHT = 3'd2,
        OP_BIAS  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    localparam logic CFG_NEURONS = 1'b0;
    localparam logic CFG_OUTPUTS = 1'b1;

    // Control fed to each cell of the readout row.
    typedef struct packed {
        logic load;   // load bias (step start)
        logic add;    // add weight (neuron fired)
        logic wr_bias;
    } cell_ctl_t;

    // Saturate a 26-bit signed sum to 24 bits.
    function automatic logic [MEM_W-1:0] sat24(input logic signed [MEM_W+1:0] v);
        logic [MEM_W-1:0] r;
        begin
            if (v > $signed({3'b000, ACC_MAX[MEM_W-2:0]}))
                r = ACC_MAX;
            else if (v < $signed({3'b111, ACC_MIN[MEM_W-2:0]}))
                r = ACC_MIN;
            else
                r = v[MEM_W-1:0];
            return r;
        end
    endfunction

endpackage

// File: src/lifr_cell.sv
// One readout cell: a bias, a weight column and an accumulator.
module lifr_cell import lifr_pkg::*; #(
    parameter int NEURONS = NEURONS_DEF,
    parameter int NA_W    = 6
) (
    input  logic                   aclk,
    input  logic                   en,
    input  cell_ctl_t              ctl,
    input  logic                   w_we,
    input  logic [NA_W-1:0]        w_addr,
    input  logic [VAL_W-1:0]       w_data,
    input  logic [NA_W-1:0]        r_addr,
    input  logic [MEM_W-1:0]       shift_in,
    input  logic                   shift,
    output logic [MEM_W-1:0]       acc
);

    logic [VAL_W-1:0] wmem [NEURONS];
    logic [VAL_W-1:0] wrd_reg;
    logic [VAL_W-1:0] bias_reg;
    logic [MEM_W-1:0] acc_reg, acc_next;

    // Weight column memory, registered read.
    always_ff @(posedge aclk) begin
        if (w_we) wmem[w_addr] <= w_data;
        wrd_reg <= wmem[r_addr];
    end

    always_comb begin
        acc_next = acc_reg;
        if (shift)
            acc_next = shift_in;
        else if (ctl.load)
            acc_next = {{(MEM_W-VAL_W){bias_reg[VAL_W-1]}}, bias_reg};
        else if (ctl.add && en)
            acc_next = sat24($signed({{2{acc_reg[MEM_W-1]}}, acc_reg}) +
                             $signed({{(MEM_W+2-VAL_W){wrd_reg[VAL_W-1]}}, wrd_reg}));
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_bias) bias_reg <= w_data;
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// File: src/lifr_neuron.sv
// Neuron update: membrane memory, decay multiply, integrate, fire.
module lifr_neuron import lifr_pkg::*; #(
    parameter int NEURONS   = NEURONS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NA_W      = 6
) (
    input  logic               aclk,
    input  logic               p_we,
    input  logic [NA_W-1:0]    p_addr,
    input  logic [DEC_W-1:0]   p_decay,
    input  logic [VAL_W-1:0]   p_thr,
    input  logic [NA_W-1:0]    r_addr,
    input  logic               calc,
    input  logic [VAL_W-1:0]   current,
    input  logic [NA_W-1:0]    m_addr,
    input  logic               m_we,
    input  logic               m_clr,
    input  logic [NA_W-1:0]    clr_addr,
    output logic               fire
);

    logic [MEM_W-1:0] mmem [NEURONS];
    logic [DEC_W-1:0] dmem [NEURONS];
    logic [VAL_W-1:0] tmem [NEURONS];
    logic [MEM_W-1:0] m_rd_reg;
    logic [DEC_W-1:0] d_rd_reg;
    logic [VAL_W-1:0] t_rd_reg;
    logic signed [MEM_W+DEC_W:0] prod;
    logic signed [MEM_W+1:0] sum;
    logic [MEM_W-1:0] mnew, msub, mfin;

    // Parameter stores.
    always_ff @(posedge aclk) begin
        if (p_we) begin
            dmem[p_addr] <= p_decay;
            tmem[p_addr] <= p_thr;
        end
        d_rd_reg <= dmem[r_addr];
        t_rd_reg <= tmem[r_addr];
        m_rd_reg <= mmem[r_addr];
    end

    // Decay, integrate, saturate, compare, subtract.
    always_comb begin
        prod = $signed(m_rd_reg) * $signed({1'b0, d_rd_reg});
        sum  = (MEM_W+2)'($signed(prod >>> FRAC_BITS) + $signed(current));
        mnew = sat24(sum);
        fire = calc && ($signed(mnew) > $signed(t_rd_reg));
        msub = sat24($signed({{2{mnew[MEM_W-1]}}, mnew}) - $signed(t_rd_reg));
        mfin = fire ? msub : mnew;
    end

    // Membrane write-back or clearing sweep.
    always_ff @(posedge aclk) begin
        if (m_clr)
            mmem[clr_addr] <= '0;
        else if (m_we)
            mmem[m_addr] <= mfin;
    end

endmodule

// File: src/lif_spiking_layer_fused_readout_unit.sv
// Top level: LIF layer with fused readout cell row.
//   channel | direction | contents
//   s_      | in        | tdata: operation, neuron_index, output_index, sample_value, decay_factor
//   m_      | out       | tdata: readout_index, readout_value; tlast: last_readout
//   cfg_    | in        | index 0 neurons_in_use, 1 outputs_in_use
// A step item goes through accept, read stores, then update and write back; a load is written at accept.
// A clear item sweeps the whole membrane memory, one neuron a cycle.
// At step end the accumulators shift out through the cell row, one per cycle,
// stalling on m_tready. After reset a sweep zeroes the membranes.
// Configuration is taken only when idle and wins over a waiting input item.
module lif_spiking_layer_fused_readout_unit import lifr_pkg::*; #(
    parameter int NEURONS   = NEURONS_DEF,
    parameter int OUTPUTS   = OUTPUTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] operation, [8:3] neuron_index, [11:9] output_index,
    // [27:12] sample_value, [40:28] decay_factor, [47:41] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] readout_index, [26:3] readout_value, [31:27] zero
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int NA_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int OA_W = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
    localparam int NC_W = $clog2(NEURONS + 1);
    localparam int OC_W = $clog2(OUTPUTS + 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CALC  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_LOAD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [OP_W-1:0]   op;
    logic [NIDX_W-1:0] nidx;
    logic [OIDX_W-1:0] oidx;
    logic [VAL_W-1:0]  sval;
    logic [DEC_W-1:0]  dval;
    assign op   = s_tdata[2:0];
    assign nidx = s_tdata[8:3];
    assign oidx = s_tdata[11:9];
    assign sval = s_tdata[27:12];
    assign dval = s_tdata[40:28];

    logic [NCFG_W-1:0] ncfg_reg;
    logic [OCFG_W-1:0] ocfg_reg;
    logic [NC_W-1:0]   nn;
    logic [OC_W-1:0]   no;
    logic [NC_W-1:0]   cnt_reg, cnt_next;
    logic [NA_W-1:0]   clr_reg, clr_next;
    logic [OC_W-1:0]   emit_reg, emit_next;
    logic [VAL_W-1:0]  cur_reg;
    logic [NA_W-1:0]   idx_reg;
    logic              s_fire, fire;
    logic              start_reg;

    // Clamp the configuration counts.
    always_comb begin
        if (ncfg_reg == '0) nn = NC_W'(1);
        else if (32'(ncfg_reg) > NEURONS) nn = NC_W'(NEURONS);
        else nn = NC_W'(ncfg_reg);
        if (ocfg_reg == '0) no = OC_W'(1);
        else if (32'(ocfg_reg) > OUTPUTS) no = OC_W'(OUTPUTS);
        else no = OC_W'(ocfg_reg);
    end

    // Take configuration only while no item is in flight.
    assign cfg_ready = (state_reg == ST_IDLE);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncfg_reg <= NCFG_W'(64);
            ocfg_reg <= OCFG_W'(8);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_NEURONS) ncfg_reg <= cfg_data;
            else ocfg_reg <= cfg_data[OCFG_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_valid;
    assign s_fire   = s_tvalid && s_tready;

    // Step index, clamped to the last neuron.
    logic [NA_W-1:0] cur_n;
    always_comb begin
        if (32'(cnt_reg) >= NEURONS) cur_n = NA_W'(NEURONS - 1);
        else cur_n = cnt_reg[NA_W-1:0];
    end

    logic nidx_ok, oidx_ok;
    assign nidx_ok = 32'(nidx) < NEURONS;
    assign oidx_ok = 32'(oidx) < OUTPUTS;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        emit_next  = emit_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + NA_W'(1);
                if (32'(clr_reg) == NEURONS - 1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (op)
                        OP_STEP:  state_next = ST_READ;
                        OP_CLEAR: begin
                            state_next = ST_CLEAR;
                            clr_next   = '0;
                        end
                        default:  state_next = ST_LOAD;
                    endcase
                end
            end
            ST_LOAD: state_next = ST_IDLE;
            ST_READ: state_next = ST_CALC;
            ST_CALC: begin
                if (cnt_reg + NC_W'(1) >= nn) begin
                    cnt_next   = '0;
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end else begin
                    cnt_next   = cnt_reg + NC_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    emit_next = emit_reg + OC_W'(1);
                    if (emit_reg + OC_W'(1) == no) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            emit_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            emit_reg  <= emit_next;
        end
    end

    // Hold the step operands.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cur_reg   <= sval;
            idx_reg   <= cur_n;
            start_reg <= (cnt_reg == '0);
        end
    end

    lifr_neuron #(
        .NEURONS(NEURONS), .FRAC_BITS(FRAC_BITS), .NA_W(NA_W)
    ) u_neuron (
        .aclk     (aclk),
        .p_we     (s_fire && op == OP_PARAM && nidx_ok),
        .p_addr   (NA_W'(nidx)),
        .p_decay  (dval),
        .p_thr    (sval),
        .r_addr   (idx_reg),
        .calc     (state_reg == ST_CALC),
        .current  (cur_reg),
        .m_addr   (idx_reg),
        .m_we     (state_reg == ST_CALC),
        .m_clr    (state_reg == ST_CLEAR),
        .clr_addr (clr_reg),
        .fire     (fire)
    );

    // Readout cell row; shifts toward cell 0 during emit.
    logic [MEM_W-1:0] acc [OUTPUTS];
    cell_ctl_t        ctl [OUTPUTS];
    logic             shift;
    assign shift = (state_reg == ST_EMIT) && m_tready;

    for (genvar j = 0; j < OUTPUTS; j++) begin : g_cell
        logic [MEM_W-1:0] sin;
        if (j == OUTPUTS - 1) begin : g_end
            assign sin = acc[j];
        end else begin : g_mid
            assign sin = acc[j+1];
        end
        assign ctl[j].load    = (state_reg == ST_READ) && start_reg;
        assign ctl[j].add     = fire;
        assign ctl[j].wr_bias = s_fire && op == OP_BIAS && 32'(oidx) == j;
        lifr_cell #(.NEURONS(NEURONS), .NA_W(NA_W)) u_cell (
            .aclk     (aclk),
            .en       (32'(j) < 32'(no)),
            .ctl      (ctl[j]),
            .w_we     (s_fire && op == OP_WEIGHT && nidx_ok && 32'(oidx) == j),
            .w_addr   (NA_W'(nidx)),
            .w_data   (sval),
            .r_addr   (idx_reg),
            .shift_in (sin),
            .shift    (shift),
            .acc      (acc[j])
        );
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = {5'b0, acc[0], 3'(emit_reg)};
    assign m_tlast  = (emit_reg + OC_W'(1) == no);

`ifndef ASSERT_OFF
    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> emit_reg < no)
        else $error("emit index past outputs in use");
    a_no_input_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CALC |=> !$past(s_tready))
        else $error("input taken during update");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) < NEURONS)
        else $error("counter out of range");
`endif

endmodule
